// ===== hw/rtl/multitap_keypad_text_entry_top_macros.svh =====
// Assertion macros shared by the checker of the keypad text entry block.
`ifndef MULTITAP_KEYPAD_TEXT_ENTRY_TOP_MACROS_SVH
`define MULTITAP_KEYPAD_TEXT_ENTRY_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MKTE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MKTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mkte_pkg.sv =====
package mkte_pkg;

  // Default number of characters kept for display.
  localparam int SHOWN_CHARS_DEF = 5;

  // Number of character ports on the result channel.
  localparam int CHAR_PORTS = 5;

  localparam logic       CMD_KEY   = 1'b0;
  localparam logic       CMD_CLEAR = 1'b1;

  localparam logic [3:0] KEY_MODE  = 4'd1;
  localparam logic [3:0] KEY_FIRST = 4'd2;
  localparam logic [3:0] KEY_LAST  = 4'd9;

  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h41;
  localparam logic [6:0] CHAR_D     = 7'h44;
  localparam logic [6:0] CHAR_G     = 7'h47;
  localparam logic [6:0] CHAR_J     = 7'h4A;
  localparam logic [6:0] CHAR_M     = 7'h4D;
  localparam logic [6:0] CHAR_P     = 7'h50;
  localparam logic [6:0] CHAR_T     = 7'h54;
  localparam logic [6:0] CHAR_W     = 7'h57;
  localparam logic [6:0] CHAR_END   = 7'h5B;

  // Group code meaning the character belongs to no letter group.
  localparam logic [3:0] GROUP_NONE = 4'd8;

  typedef struct packed {
    logic [CHAR_PORTS-1:0][6:0] chars;
    logic                       number_mode;
    logic [2:0]                 length;
  } result_t;

  // First letter of a group; the code after the last group gives the end bound.
  function automatic logic [6:0] group_start(input logic [3:0] g);
    logic [6:0] c;
    case (g)
      4'd0:    c = CHAR_A;
      4'd1:    c = CHAR_D;
      4'd2:    c = CHAR_G;
      4'd3:    c = CHAR_J;
      4'd4:    c = CHAR_M;
      4'd5:    c = CHAR_P;
      4'd6:    c = CHAR_T;
      4'd7:    c = CHAR_W;
      default: c = CHAR_END;
    endcase
    return c;
  endfunction

  // Letter group of a character, GROUP_NONE when it is not a letter.
  function automatic logic [3:0] group_of(input logic [6:0] c);
    logic [3:0] g;
    g = GROUP_NONE;
    for (int i = 0; i < 8; i++) begin
      if (c >= group_start(4'(i)) && c < group_start(4'(i + 1))) begin
        g = 4'(i);
      end
    end
    return g;
  endfunction

endpackage

// ===== hw/rtl/mkte_core.sv =====
module mkte_core #(
  parameter int SHOWN_CHARS = mkte_pkg::SHOWN_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              in_cmd,
  input  logic [3:0]        in_key,
  output mkte_pkg::result_t result
);
  import mkte_pkg::*;

  localparam int CNT_W = $clog2(SHOWN_CHARS + 2);

  logic [6:0]       shown_r   [SHOWN_CHARS];
  logic [6:0]       shown_nxt [SHOWN_CHARS];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [6:0]       last_r, last_nxt;
  logic             mode_r, mode_nxt;

  logic [3:0] grp;
  logic       match;
  logic [6:0] cyc_char;
  logic [6:0] new_char;

  always_comb begin
    shown_nxt = shown_r;
    count_nxt = count_r;
    last_nxt  = last_r;
    mode_nxt  = mode_r;

    grp      = {1'b0, 3'(in_key - KEY_FIRST)};
    match    = (count_r != '0) && (group_of(last_r) == grp);
    cyc_char = last_r + 7'd1;
    if (cyc_char == group_start(grp + 4'd1)) begin
      cyc_char = group_start(grp);
    end
    new_char = mode_r ? (CHAR_ZERO + {3'b000, in_key}) : group_start(grp);

    if (in_cmd == CMD_CLEAR) begin
      for (int i = 0; i < SHOWN_CHARS; i++) begin
        shown_nxt[i] = CHAR_SPACE;
      end
      count_nxt = '0;
      last_nxt  = CHAR_SPACE;
      mode_nxt  = 1'b0;
    end else if (in_key == KEY_MODE) begin
      mode_nxt = ~mode_r;
    end else if (in_key >= KEY_FIRST && in_key <= KEY_LAST) begin
      if (!mode_r && match) begin
        // Cycle the last letter; a hidden one only moves the tracked copy.
        for (int i = 0; i < SHOWN_CHARS; i++) begin
          if (count_r == CNT_W'(i + 1)) begin
            shown_nxt[i] = cyc_char;
          end
        end
        last_nxt = cyc_char;
      end else begin
        for (int i = 0; i < SHOWN_CHARS; i++) begin
          if (count_r == CNT_W'(i)) begin
            shown_nxt[i] = new_char;
          end
        end
        if (count_r <= CNT_W'(SHOWN_CHARS)) begin
          count_nxt = count_r + CNT_W'(1);
        end
        last_nxt = new_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SHOWN_CHARS; i++) begin
        shown_r[i] <= CHAR_SPACE;
      end
      count_r <= '0;
      last_r  <= CHAR_SPACE;
      mode_r  <= 1'b0;
    end else if (accept) begin
      shown_r <= shown_nxt;
      count_r <= count_nxt;
      last_r  <= last_nxt;
      mode_r  <= mode_nxt;
    end
  end

  // The result word reflects the state after this item's update.
  for (genvar p = 0; p < CHAR_PORTS; p++) begin : g_char
    if (p < SHOWN_CHARS) begin : g_shown
      assign result.chars[p] = shown_nxt[p];
    end else begin : g_blank
      assign result.chars[p] = CHAR_SPACE;
    end
  end

  assign result.number_mode = mode_nxt;
  assign result.length      = 3'(count_nxt);

endmodule

// ===== hw/rtl/mkte_outq.sv =====
module mkte_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mkte_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output mkte_pkg::result_t out_data
);
  import mkte_pkg::*;

  logic    main_valid_r, main_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_nxt       = push_data;
        main_valid_nxt = push;
      end
    end else if (push) begin
      // Head word is held; the new word waits in the skid slot.
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

// ===== hw/rtl/multitap_keypad_text_entry_top.sv =====
// Channel   Direction  Handshake           Word
// in_       input      in_valid/in_stall   in_cmd, in_key
// out_      output     out_valid/out_stall out_char_0..4, out_number_mode, out_length
//
// Each accepted word updates the text state in the cycle it is taken, and its
// result word is registered into the output queue: one word per cycle while in_stall is low.
// rst_n is synchronous and active low; it empties the text and selects letter mode.
// A two-word output queue lets an input word be taken while a result is stalled;
// in_stall rises only when both queue slots hold results not yet taken.
module multitap_keypad_text_entry_top #(
  parameter int SHOWN_CHARS = mkte_pkg::SHOWN_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [3:0] in_key,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_char_0,
  output logic [6:0] out_char_1,
  output logic [6:0] out_char_2,
  output logic [6:0] out_char_3,
  output logic [6:0] out_char_4,
  output logic       out_number_mode,
  output logic [2:0] out_length
);
  import mkte_pkg::*;

  logic    accept;
  result_t core_result;
  result_t head_result;

  // A word is taken whenever the output queue has room for its result.
  assign accept = in_valid && !in_stall;

  // The text state and the multi-tap decision logic live in the core.
  mkte_core #(
    .SHOWN_CHARS(SHOWN_CHARS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_cmd (in_cmd),
    .in_key (in_key),
    .result (core_result)
  );

  // The result register with its skid slot decouples the two channels.
  mkte_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (core_result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head_result)
  );

  assign out_char_0      = head_result.chars[0];
  assign out_char_1      = head_result.chars[1];
  assign out_char_2      = head_result.chars[2];
  assign out_char_3      = head_result.chars[3];
  assign out_char_4      = head_result.chars[4];
  assign out_number_mode = head_result.number_mode;
  assign out_length      = head_result.length;

endmodule

// ===== hw/rtl/mkte_checker.sv =====
`include "multitap_keypad_text_entry_top_macros.svh"

module mkte_checker #(
  parameter int SHOWN_CHARS = mkte_pkg::SHOWN_CHARS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] out_char_0,
  input logic [6:0] out_char_1,
  input logic [6:0] out_char_2,
  input logic [6:0] out_char_3,
  input logic [6:0] out_char_4,
  input logic       out_number_mode,
  input logic [2:0] out_length
);
  import mkte_pkg::*;

  logic in_take;
  assign in_take = in_valid && !in_stall;

  // Every accepted word leaves a result waiting on the next cycle.
  `MKTE_ASSERT_NEXT(a_take_gives_result, in_take, out_valid, "accepted word gave no result")

  // The input side is only held back while a result is waiting.
  `MKTE_ASSERT_IMPL(a_stall_needs_backlog, in_stall, out_valid, "input stalled with no backlog")

  // A stalled result word holds its contents.
  `MKTE_ASSERT_NEXT(a_stalled_word_holds, out_valid && out_stall,
                    out_valid && $stable(out_length) && $stable(out_char_0)
                    && $stable(out_char_1) && $stable(out_char_2) && $stable(out_char_3)
                    && $stable(out_char_4) && $stable(out_number_mode),
                    "stalled result word changed")

  // Empty text shows a space on the first and the last character port.
  `MKTE_ASSERT_IMPL(a_empty_is_blank, (SHOWN_CHARS < 7) && out_valid && out_length == 3'd0,
                    out_char_0 == CHAR_SPACE && out_char_4 == CHAR_SPACE,
                    "empty text shows characters")

endmodule

bind multitap_keypad_text_entry_top mkte_checker #(.SHOWN_CHARS(SHOWN_CHARS)) u_mkte_checker (.*);
